// ===== sv/pmhc_pkg.sv =====
// Shared types, constants and helper functions of the pedal multi-tap cluster selector.
package pmhc_pkg;

  localparam int MAX_TAPS     = 6;
  localparam int SEL_BUTTONS  = 3;
  localparam int SEL_IDX_W    = (SEL_BUTTONS > 1) ? $clog2(SEL_BUTTONS) : 1;
  localparam int GROUP_SIZE   = 3;
  localparam int NUM_CLUSTERS = 2 * GROUP_SIZE;
  localparam int TAPS_CAP     = 2 * GROUP_SIZE;
  localparam int TAPS_W       = $clog2(MAX_TAPS + 1);
  localparam int CLUSTER_W    = 3;
  localparam int TIMER_W      = 12;
  localparam int MASK_W       = 18;
  localparam int ENTRY_W      = 5;
  localparam int ENTRY_MAX    = NUM_CLUSTERS * GROUP_SIZE - 1;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 18;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  localparam logic [TIMER_W-1:0] WINDOW_RESET     = 12'd800;
  localparam logic [TIMER_W-1:0] GROUP_HOLD_RESET = 12'd500;
  localparam logic [TIMER_W-1:0] HOLD_THR_RESET   = 12'd200;
  localparam logic [MASK_W-1:0]  HOLD_MASK_RESET  = 18'd163840;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MULTITAP_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_HOLD_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MASK       = 2'd3;

  // Input operation codes.
  localparam logic [2:0] OP_TICK          = 3'd0;
  localparam logic [2:0] OP_PEDAL_PRESS   = 3'd1;
  localparam logic [2:0] OP_PEDAL_RELEASE = 3'd2;
  localparam logic [2:0] OP_SEL_PRESS     = 3'd3;
  localparam logic [2:0] OP_SEL_RELEASE   = 3'd4;
  localparam logic [2:0] OP_TOGGLE        = 3'd5;

  // Result slots: one per select button (slot 0 also carries a single cluster
  // change), one for hold start or release, one for the macro commit.
  localparam int NUM_SLOTS   = SEL_BUTTONS + 2;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int SLOT_SINGLE = 0;
  localparam int SLOT_HOLD   = SEL_BUTTONS;
  localparam int SLOT_COMMIT = SEL_BUTTONS + 1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_PEDAL_PRESS,
    CMD_PEDAL_RELEASE,
    CMD_SEL_PRESS,
    CMD_SEL_RELEASE,
    CMD_TOGGLE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [SEL_IDX_W-1:0]   sel;
  } cmd_t;

  typedef enum logic [1:0] {
    EV_CLUSTER      = 2'd0,
    EV_MACRO        = 2'd1,
    EV_HOLD_START   = 2'd2,
    EV_HOLD_RELEASE = 2'd3
  } ev_t;

  typedef struct packed {
    ev_t                  ev;
    logic [CLUSTER_W-1:0] cluster;
    logic [1:0]           taps;
  } result_t;

  typedef struct packed {
    logic [TIMER_W-1:0] window;
    logic [TIMER_W-1:0] group_hold;
    logic [TIMER_W-1:0] hold_thr;
    logic [MASK_W-1:0]  hold_mask;
  } cfg_t;

  function automatic logic [TIMER_W-1:0] sat_inc(logic [TIMER_W-1:0] t);
    return (t == TIMER_MAX) ? t : t + 1'b1;
  endfunction

  function automatic logic group_of(logic [CLUSTER_W-1:0] c);
    return c >= CLUSTER_W'(GROUP_SIZE);
  endfunction

  // Same position in the other group.
  function automatic logic [CLUSTER_W-1:0] other_cluster(logic [CLUSTER_W-1:0] c);
    return group_of(c) ? c - CLUSTER_W'(GROUP_SIZE) : c + CLUSTER_W'(GROUP_SIZE);
  endfunction

  // Cluster at a position of a group; anything past the last cluster becomes zero.
  function automatic logic [CLUSTER_W-1:0] pick_cluster(logic grp,
                                                        logic [SEL_IDX_W-1:0] pos);
    logic [3:0] v;
    v = (grp ? 4'(GROUP_SIZE) : 4'd0) + 4'(pos);
    return (v > 4'(NUM_CLUSTERS - 1)) ? '0 : CLUSTER_W'(v);
  endfunction

  function automatic logic [CLUSTER_W-1:0] entry_cluster(logic [ENTRY_W-1:0] e);
    logic [CLUSTER_W-1:0] q;
    q = '0;
    for (int k = 1; k < NUM_CLUSTERS; k++) begin
      if (e >= ENTRY_W'(GROUP_SIZE * k)) q = CLUSTER_W'(k);
    end
    return q;
  endfunction

  function automatic logic [1:0] entry_taps(logic [ENTRY_W-1:0] e);
    logic [ENTRY_W-1:0] r;
    r = e - ENTRY_W'(entry_cluster(e)) * ENTRY_W'(GROUP_SIZE) + 1'b1;
    return r[1:0];
  endfunction

endpackage

// ===== sv/pedal_multitap_hold_cluster_select.sv =====
// Top level of the pedal multi-tap and hold detector with cluster selection.
//
//  Channel  Direction  Handshake            Payload
//  in       input      in_valid/in_ready    op[2:0], button[1:0]
//  out      output     out_valid/out_ready  event_res[1:0], cluster[2:0], tap_count[1:0], last
//  cfg      input      cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[17:0]
//
// Each item occupies the back executor until the results it causes (up to four for a tick)
// have drained; the executor emits one result beat per cycle unless the output stalls.
// A two-entry command queue sits between the front decoder and the executor, so input
// beats keep being taken while results drain. The configuration port is always ready.
// Reset is synchronous and clears all detector state and the queue.
// A stalled output holds the current result; the queue then fills and drops in_ready.
module pedal_multitap_hold_cluster_select (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      op,
  input  logic [1:0]                      button,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      event_res,
  output logic [2:0]                      cluster,
  output logic [1:0]                      tap_count,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pmhc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmhc_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers. The sender writes them only while the block is idle.
  pmhc_pkg::cfg_t cfg;

  logic           push_valid;
  logic           push_ready;
  pmhc_pkg::cmd_t push_data;
  logic           cmd_valid;
  logic           cmd_pop;
  pmhc_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window     <= pmhc_pkg::WINDOW_RESET;
      cfg.group_hold <= pmhc_pkg::GROUP_HOLD_RESET;
      cfg.hold_thr   <= pmhc_pkg::HOLD_THR_RESET;
      cfg.hold_mask  <= pmhc_pkg::HOLD_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pmhc_pkg::REG_MULTITAP_WINDOW: cfg.window     <= cfg_data[pmhc_pkg::TIMER_W-1:0];
        pmhc_pkg::REG_GROUP_HOLD_TIME: cfg.group_hold <= cfg_data[pmhc_pkg::TIMER_W-1:0];
        pmhc_pkg::REG_HOLD_THRESHOLD:  cfg.hold_thr   <= cfg_data[pmhc_pkg::TIMER_W-1:0];
        pmhc_pkg::REG_HOLD_MASK:       cfg.hold_mask  <= cfg_data[pmhc_pkg::MASK_W-1:0];
      endcase
    end
  end

  // The front decodes every beat; unused ops and bad button indexes are
  // accepted and dropped without reaching the queue.
  pmhc_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .button     (button),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pmhc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (cmd_valid),
    .pop        (cmd_pop),
    .pop_data   (cmd)
  );

  // The back takes the next command in the same cycle the last result of the
  // previous one moves into the output register.
  pmhc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .event_res  (event_res),
    .cluster    (cluster),
    .tap_count  (tap_count),
    .last       (last)
  );

endmodule

// ===== sv/pmhc_queue.sv =====
// Short command queue between the front decoder and the back executor.
module pmhc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  pmhc_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output pmhc_pkg::cmd_t pop_data
);

  pmhc_pkg::cmd_t                  entries [pmhc_pkg::QDEPTH];
  logic [pmhc_pkg::QPTR_W-1:0]     wr_ptr;
  logic [pmhc_pkg::QPTR_W-1:0]     rd_ptr;
  logic [pmhc_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count != pmhc_pkg::QCNT_W'(pmhc_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == pmhc_pkg::QPTR_W'(pmhc_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == pmhc_pkg::QPTR_W'(pmhc_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/pmhc_front.sv =====
// Front decoder: accepts input beats and classifies them into queue commands.
module pmhc_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           op,
  input  logic [1:0]           button,
  output logic                 push_valid,
  input  logic                 push_ready,
  output pmhc_pkg::cmd_t       push_data
);

  logic sel_ok;
  logic keep;

  assign sel_ok = ({1'b0, button} < 3'(pmhc_pkg::SEL_BUTTONS));

  // Unused ops and select ops on a missing button are taken and dropped.
  always_comb begin
    keep           = 1'b1;
    push_data.sel  = button[pmhc_pkg::SEL_IDX_W-1:0];
    push_data.kind = pmhc_pkg::CMD_TICK;
    unique case (op)
      pmhc_pkg::OP_TICK:          push_data.kind = pmhc_pkg::CMD_TICK;
      pmhc_pkg::OP_PEDAL_PRESS:   push_data.kind = pmhc_pkg::CMD_PEDAL_PRESS;
      pmhc_pkg::OP_PEDAL_RELEASE: push_data.kind = pmhc_pkg::CMD_PEDAL_RELEASE;
      pmhc_pkg::OP_SEL_PRESS: begin
        push_data.kind = pmhc_pkg::CMD_SEL_PRESS;
        keep           = sel_ok;
      end
      pmhc_pkg::OP_SEL_RELEASE: begin
        push_data.kind = pmhc_pkg::CMD_SEL_RELEASE;
        keep           = sel_ok;
      end
      pmhc_pkg::OP_TOGGLE:        push_data.kind = pmhc_pkg::CMD_TOGGLE;
      default:                    keep = 1'b0;
    endcase
  end

  assign in_ready   = push_ready;
  assign push_valid = in_valid && keep;

endmodule

// ===== sv/pmhc_back.sv =====
// Back executor: keeps the detector state, runs one command and drains its results.
module pmhc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  pmhc_pkg::cfg_t                  cfg,
  input  logic                            cmd_valid,
  input  pmhc_pkg::cmd_t                  cmd,
  output logic                            cmd_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      event_res,
  output logic [pmhc_pkg::CLUSTER_W-1:0]  cluster,
  output logic [1:0]                      tap_count,
  output logic                            last
);

  localparam int SB = pmhc_pkg::SEL_BUTTONS;
  localparam int TW = pmhc_pkg::TIMER_W;

  // Detector state.
  logic [pmhc_pkg::CLUSTER_W-1:0] cur_cluster;
  logic [SB-1:0]                  sel_down;
  logic [SB-1:0]                  sel_fired;
  logic [TW-1:0]                  sel_timer [SB];
  logic                           pedal_down;
  logic                           hold_primed;
  logic                           hold_running;
  logic [pmhc_pkg::TAPS_W-1:0]    taps_pending;
  logic [TW-1:0]                  tap_timer;
  logic [TW-1:0]                  hold_count;
  logic [pmhc_pkg::ENTRY_W-1:0]   armed_entry;

  logic [pmhc_pkg::CLUSTER_W-1:0] cur_cluster_next;
  logic [SB-1:0]                  sel_down_next;
  logic [SB-1:0]                  sel_fired_next;
  logic [TW-1:0]                  sel_timer_next [SB];
  logic                           pedal_down_next;
  logic                           hold_primed_next;
  logic                           hold_running_next;
  logic [pmhc_pkg::TAPS_W-1:0]    taps_pending_next;
  logic [TW-1:0]                  tap_timer_next;
  logic [TW-1:0]                  hold_count_next;
  logic [pmhc_pkg::ENTRY_W-1:0]   armed_entry_next;

  // Result slots of the command being drained.
  pmhc_pkg::result_t              slots [pmhc_pkg::NUM_SLOTS];
  logic [pmhc_pkg::NUM_SLOTS-1:0] slot_mask;
  pmhc_pkg::result_t              slots_next [pmhc_pkg::NUM_SLOTS];
  logic [pmhc_pkg::NUM_SLOTS-1:0] slot_mask_next;

  pmhc_pkg::result_t              out_res;

  logic [pmhc_pkg::SLOT_W-1:0]    drain_idx;
  logic [pmhc_pkg::NUM_SLOTS-1:0] rest_mask;
  logic [pmhc_pkg::NUM_SLOTS-1:0] mask_after;
  logic                           out_free;
  logic                           drain;

  // Command evaluation.
  always_comb begin
    logic [pmhc_pkg::TAPS_W-1:0]  tv;
    logic [pmhc_pkg::ENTRY_W-1:0] e;
    logic                         tap_ok;
    logic [pmhc_pkg::CLUSTER_W-1:0] cl;

    cur_cluster_next  = cur_cluster;
    sel_down_next     = sel_down;
    sel_fired_next    = sel_fired;
    sel_timer_next    = sel_timer;
    pedal_down_next   = pedal_down;
    hold_primed_next  = hold_primed;
    hold_running_next = hold_running;
    taps_pending_next = taps_pending;
    tap_timer_next    = tap_timer;
    hold_count_next   = hold_count;
    armed_entry_next  = armed_entry;
    slot_mask_next    = '0;
    for (int k = 0; k < pmhc_pkg::NUM_SLOTS; k++) begin
      slots_next[k] = '{ev: pmhc_pkg::EV_CLUSTER, cluster: '0, taps: 2'd0};
    end
    tv     = '0;
    e      = '0;
    tap_ok = 1'b0;
    cl     = cur_cluster;

    unique case (cmd.kind)
      pmhc_pkg::CMD_TICK: begin
        // Long presses in button order; each may move the cluster for the next.
        for (int i = 0; i < SB; i++) begin
          if (sel_down_next[i]) sel_timer_next[i] = pmhc_pkg::sat_inc(sel_timer_next[i]);
          if (sel_down_next[i] && !sel_fired_next[i] &&
              sel_timer_next[i] >= cfg.group_hold) begin
            cur_cluster_next = pmhc_pkg::pick_cluster(!pmhc_pkg::group_of(cur_cluster_next),
                                                      pmhc_pkg::SEL_IDX_W'(i));
            sel_fired_next[i] = 1'b1;
            slot_mask_next[i] = 1'b1;
            slots_next[i] = '{ev: pmhc_pkg::EV_CLUSTER, cluster: cur_cluster_next,
                              taps: 2'd0};
          end
        end
        if (hold_primed) hold_count_next = pmhc_pkg::sat_inc(hold_count);
        if (hold_primed && pedal_down && !hold_running && hold_count_next >= cfg.hold_thr) begin
          hold_running_next = 1'b1;
          slot_mask_next[pmhc_pkg::SLOT_HOLD] = 1'b1;
          slots_next[pmhc_pkg::SLOT_HOLD] = '{ev: pmhc_pkg::EV_HOLD_START,
                                             cluster: pmhc_pkg::entry_cluster(armed_entry),
                                             taps: pmhc_pkg::entry_taps(armed_entry)};
        end
        if (taps_pending != '0) tap_timer_next = pmhc_pkg::sat_inc(tap_timer);
        if (!hold_running_next && !hold_primed && taps_pending != '0 &&
            tap_timer_next >= cfg.window) begin
          tv = (taps_pending > pmhc_pkg::TAPS_W'(pmhc_pkg::TAPS_CAP)) ?
               pmhc_pkg::TAPS_W'(pmhc_pkg::TAPS_CAP) : taps_pending;
          cl = cur_cluster_next;
          if (tv > pmhc_pkg::TAPS_W'(pmhc_pkg::GROUP_SIZE)) begin
            cl = pmhc_pkg::other_cluster(cur_cluster_next);
            tv = tv - pmhc_pkg::TAPS_W'(pmhc_pkg::GROUP_SIZE);
          end
          slot_mask_next[pmhc_pkg::SLOT_COMMIT] = 1'b1;
          slots_next[pmhc_pkg::SLOT_COMMIT] = '{ev: pmhc_pkg::EV_MACRO, cluster: cl,
                                               taps: tv[1:0]};
          taps_pending_next = '0;
          tap_timer_next    = '0;
        end
      end
      pmhc_pkg::CMD_PEDAL_PRESS: begin
        pedal_down_next = 1'b1;
        if (taps_pending < pmhc_pkg::TAPS_W'(pmhc_pkg::MAX_TAPS)) begin
          taps_pending_next = taps_pending + 1'b1;
        end
        tap_timer_next = '0;
        tap_ok = (taps_pending_next >= pmhc_pkg::TAPS_W'(1)) &&
                 (taps_pending_next <= pmhc_pkg::TAPS_W'(pmhc_pkg::GROUP_SIZE));
        e = pmhc_pkg::ENTRY_W'(cur_cluster) * pmhc_pkg::ENTRY_W'(pmhc_pkg::GROUP_SIZE) +
            pmhc_pkg::ENTRY_W'(taps_pending_next) - 1'b1;
        if (tap_ok && cfg.hold_mask[e]) begin
          hold_primed_next = 1'b1;
          hold_count_next  = '0;
          // A hold already running keeps the entry that started it.
          if (!hold_running) armed_entry_next = e;
        end else begin
          hold_primed_next = 1'b0;
        end
      end
      pmhc_pkg::CMD_PEDAL_RELEASE: begin
        pedal_down_next = 1'b0;
        if (hold_running) begin
          slot_mask_next[pmhc_pkg::SLOT_HOLD] = 1'b1;
          slots_next[pmhc_pkg::SLOT_HOLD] = '{ev: pmhc_pkg::EV_HOLD_RELEASE,
                                             cluster: pmhc_pkg::entry_cluster(armed_entry),
                                             taps: pmhc_pkg::entry_taps(armed_entry)};
          hold_running_next = 1'b0;
          taps_pending_next = '0;
          tap_timer_next    = '0;
        end
        hold_primed_next = 1'b0;
      end
      pmhc_pkg::CMD_SEL_PRESS: begin
        sel_down_next[cmd.sel]  = 1'b1;
        sel_fired_next[cmd.sel] = 1'b0;
        sel_timer_next[cmd.sel] = '0;
      end
      pmhc_pkg::CMD_SEL_RELEASE: begin
        sel_down_next[cmd.sel] = 1'b0;
        if (!sel_fired[cmd.sel]) begin
          cur_cluster_next = pmhc_pkg::pick_cluster(pmhc_pkg::group_of(cur_cluster), cmd.sel);
          slot_mask_next[pmhc_pkg::SLOT_SINGLE] = 1'b1;
          slots_next[pmhc_pkg::SLOT_SINGLE] = '{ev: pmhc_pkg::EV_CLUSTER,
                                               cluster: cur_cluster_next, taps: 2'd0};
        end
      end
      pmhc_pkg::CMD_TOGGLE: begin
        cur_cluster_next = pmhc_pkg::other_cluster(cur_cluster);
        slot_mask_next[pmhc_pkg::SLOT_SINGLE] = 1'b1;
        slots_next[pmhc_pkg::SLOT_SINGLE] = '{ev: pmhc_pkg::EV_CLUSTER,
                                             cluster: cur_cluster_next, taps: 2'd0};
      end
      default: begin
        slot_mask_next = '0;
      end
    endcase
  end

  // Drain the lowest pending slot into the output register.
  always_comb begin
    drain_idx = '0;
    for (int k = pmhc_pkg::NUM_SLOTS - 1; k >= 0; k--) begin
      if (slot_mask[k]) drain_idx = pmhc_pkg::SLOT_W'(k);
    end
    rest_mask            = slot_mask;
    rest_mask[drain_idx] = 1'b0;
  end

  assign out_free   = !out_valid || out_ready;
  assign drain      = (slot_mask != '0) && out_free;
  assign mask_after = drain ? rest_mask : slot_mask;
  assign cmd_pop    = cmd_valid && (mask_after == '0);

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      slots <= slots_next;
    end
    if (drain) begin
      out_res <= slots[drain_idx];
      last    <= (rest_mask == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_cluster  <= '0;
      sel_down     <= '0;
      sel_fired    <= '0;
      for (int i = 0; i < SB; i++) sel_timer[i] <= '0;
      pedal_down   <= 1'b0;
      hold_primed  <= 1'b0;
      hold_running <= 1'b0;
      taps_pending <= '0;
      tap_timer    <= '0;
      hold_count   <= '0;
      armed_entry  <= '0;
      slot_mask    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd_pop) begin
        cur_cluster  <= cur_cluster_next;
        sel_down     <= sel_down_next;
        sel_fired    <= sel_fired_next;
        sel_timer    <= sel_timer_next;
        pedal_down   <= pedal_down_next;
        hold_primed  <= hold_primed_next;
        hold_running <= hold_running_next;
        taps_pending <= taps_pending_next;
        tap_timer    <= tap_timer_next;
        hold_count   <= hold_count_next;
        armed_entry  <= armed_entry_next;
        slot_mask    <= slot_mask_next;
      end else begin
        slot_mask    <= mask_after;
      end
      if (drain) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign event_res = out_res.ev;
  assign cluster   = out_res.cluster;
  assign tap_count = out_res.taps;

`ifndef SYNTHESIS
  a_cluster_range: assert property (@(posedge clk) disable iff (rst)
    cur_cluster <= pmhc_pkg::CLUSTER_W'(pmhc_pkg::NUM_CLUSTERS - 1))
    else $error("current cluster out of range");

  a_taps_range: assert property (@(posedge clk) disable iff (rst)
    taps_pending <= pmhc_pkg::TAPS_W'(pmhc_pkg::MAX_TAPS))
    else $error("pending tap count above its limit");

  a_entry_range: assert property (@(posedge clk) disable iff (rst)
    armed_entry <= pmhc_pkg::ENTRY_W'(pmhc_pkg::ENTRY_MAX))
    else $error("armed hold entry out of range");

  a_burst_gapless: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("results of one item were not delivered back to back");
`endif

endmodule
